// File: rtl/core/fat12_cluster_chain_walk_macros.svh
`ifndef FAT12_CLUSTER_CHAIN_WALK_MACROS_SVH
`define FAT12_CLUSTER_CHAIN_WALK_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define FCCW_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fat12 chain walk: same-cycle check failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define FCCW_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fat12 chain walk: next-cycle check failed");

`endif

// File: rtl/core/fccw_pkg.sv
package fccw_pkg;

   // Sequencer states of the chain walker.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ_LO,
      ST_READ_HI,
      ST_EMIT
   } state_type;

   // Command codes carried in the request tuser.
   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_WALK  = 1'b1;

   // Error codes carried in the response tuser.
   localparam logic [1:0] ERR_NONE  = 2'd0;
   localparam logic [1:0] ERR_CHAIN = 2'd1;
   localparam logic [1:0] ERR_LOW   = 2'd2;

   // Register indexes on the configuration port.
   localparam logic REG_SPC    = 1'b0;
   localparam logic REG_DSTART = 1'b1;

   // Register reset values.
   localparam logic [7:0]  SPC_RESET    = 8'd1;
   localparam logic [15:0] DSTART_RESET = 16'd33;

   // FAT12 markers.
   localparam logic [11:0] END_MARK      = 12'hFF8;
   localparam logic [11:0] FIRST_CLUSTER = 12'd2;

endpackage

// File: rtl/core/fccw_ram.sv
module fccw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8192
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // One write port and one registered read port; read data holds without re.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// File: rtl/core/fat12_cluster_chain_walk.sv
// FAT12 cluster chain walker.
// Request channel (req_*): tuser is the command. A write transfer stores one
// byte of the allocation table; a walk transfer
// names a start cluster. Response channel (rsp_*): one transfer per cluster
// of the chain, with the cluster and its first sector in tdata, the error
// code in tuser and tlast on the final element of the walk.
// Sequence: each cluster takes two reads of the single table RAM read port
// (ST_READ_LO, ST_READ_HI), then the result (ST_EMIT), where a stalled receiver
// can hold it. req_tready is low for the whole walk. A cluster below two skips
// the second read and goes straight to the result.
// The response sits in an output register, so a stalled receiver only holds
// the walk at its next result; a finished walk leaves the block ready at once.
// Reset returns the sequencer to idle, drops rsp_tvalid and sets the
// registers to one sector per cluster and a data start of 33. The table contents
// are undefined after reset and must be written before a walk reads them.
// Configuration: APB, register 0 at byte 0, register 1 at byte 4.
`include "fat12_cluster_chain_walk_macros.svh"

module fat12_cluster_chain_walk #(
   parameter int TABLE_BYTES = 8192,
   parameter int MAX_CHAIN   = 64
) (
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,  // table_address[12:0], table_byte[20:13], start_cluster[32:21]
   input  logic        req_tuser,  // cmd[0]
   // Response channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,  // cluster[11:0], first_sector[31:12]
   output logic        rsp_tlast,  // last
   output logic [1:0]  rsp_tuser,  // error[1:0]
   // Configuration port.
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int AW = $clog2(TABLE_BYTES);
   localparam int CW = $clog2(MAX_CHAIN + 1);

   fccw_pkg::state_type state_ff, state_in;

   logic [7:0]    spc_ff, spc_in;
   logic [15:0]   dstart_ff, dstart_in;
   logic [11:0]   cur_ff, cur_in;
   logic [CW-1:0] count_ff, count_in;
   logic [7:0]    lo_ff, lo_in;
   logic          lo_oor_ff, lo_oor_in;
   logic          hi_oor_ff, hi_oor_in;
   logic [19:0]   sec_ff, sec_in;

   logic          out_valid_ff, out_valid_in;
   logic [11:0]   out_cluster_ff, out_cluster_in;
   logic [19:0]   out_sector_ff, out_sector_in;
   logic          out_last_ff, out_last_in;
   logic [1:0]    out_err_ff, out_err_in;

   logic          req_xfer;
   logic          csr_write;
   logic [12:0]   req_addr;
   logic [7:0]    req_byte;
   logic [11:0]   req_start;
   logic [12:0]   word_at;
   logic [12:0]   rd_addr;
   logic          rd_oor;
   logic          ram_we;
   logic          ram_re;
   logic [7:0]    ram_rdata;
   logic [15:0]   fat_word;
   logic [11:0]   next_cluster;
   logic          low_cluster;
   logic          out_load;
   logic [19:0]   res_sector;
   logic          res_last;
   logic [1:0]    res_err;
   logic [11:0]   cl_off;

   logic          chk_err;
   logic          chk_low;
   logic          chk_low_ok;
   logic          chk_busy;
   logic          chk_count_ok;
   logic          chk_more;
   logic          chk_read_lo;

   // Request field unpacking and the accept strobe.
   assign req_addr  = req_tdata[12:0];
   assign req_byte  = req_tdata[20:13];
   assign req_start = req_tdata[32:21];
   assign req_tready = (state_ff == fccw_pkg::ST_IDLE);
   assign req_xfer   = req_tvalid && req_tready;

   // Configuration registers.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   always_comb begin
      spc_in    = spc_ff;
      dstart_in = dstart_ff;
      if (csr_write) begin
         unique case (csr_paddr[2])
            fccw_pkg::REG_SPC:    spc_in    = csr_pwdata[7:0];
            fccw_pkg::REG_DSTART: dstart_in = csr_pwdata[15:0];
            default:              spc_in    = spc_ff;
         endcase
      end
   end
   always_comb begin
      unique case (csr_paddr[2])
         fccw_pkg::REG_SPC:    csr_prdata = {24'd0, spc_ff};
         fccw_pkg::REG_DSTART: csr_prdata = {16'd0, dstart_ff};
         default:              csr_prdata = 32'd0;
      endcase
   end

   // Table byte offset of the current entry is cluster*3/2; the second read
   // takes the following byte.
   assign word_at = 13'(cur_ff) + 13'(cur_ff[11:1]);
   assign rd_addr = (state_ff == fccw_pkg::ST_READ_LO) ? word_at : word_at + 13'd1;
   assign rd_oor  = ({1'b0, rd_addr} >= 14'(TABLE_BYTES));
   assign ram_re  = (state_ff == fccw_pkg::ST_READ_LO) || (state_ff == fccw_pkg::ST_READ_HI);
   assign ram_we  = req_xfer && (req_tuser == fccw_pkg::CMD_WRITE)
                    && ({1'b0, req_addr} < 14'(TABLE_BYTES));

   fccw_ram #(
      .WIDTH (8),
      .DEPTH (TABLE_BYTES)
   ) u_table (
      .clock (clock),
      .we    (ram_we),
      .waddr (req_addr[AW-1:0]),
      .wdata (req_byte),
      .re    (ram_re),
      .raddr (rd_addr[AW-1:0]),
      .rdata (ram_rdata)
   );

   // Decode the 12-bit entry; bytes beyond the table read as zero.
   assign fat_word     = {(hi_oor_ff ? 8'd0 : ram_rdata), (lo_oor_ff ? 8'd0 : lo_ff)};
   assign next_cluster = cur_ff[0] ? fat_word[15:4] : fat_word[11:0];
   assign low_cluster  = (cur_ff < fccw_pkg::FIRST_CLUSTER);
   assign out_load     = (state_ff == fccw_pkg::ST_EMIT) && (!out_valid_ff || rsp_tready);
   assign cl_off       = cur_ff - fccw_pkg::FIRST_CLUSTER;

   // Result classification for the current cluster.
   always_comb begin
      res_sector = sec_ff;
      res_last   = 1'b0;
      res_err    = fccw_pkg::ERR_NONE;
      if (low_cluster) begin
         res_sector = 20'd0;
         res_last   = 1'b1;
         res_err    = fccw_pkg::ERR_LOW;
      end else if (next_cluster >= fccw_pkg::END_MARK) begin
         res_last   = 1'b1;
      end else if (count_ff == CW'(MAX_CHAIN - 1)) begin
         res_last   = 1'b1;
         res_err    = fccw_pkg::ERR_CHAIN;
      end
   end

   // Next state of the sequencer.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         fccw_pkg::ST_IDLE: begin
            if (req_xfer && (req_tuser == fccw_pkg::CMD_WALK)) begin
               state_in = fccw_pkg::ST_READ_LO;
            end
         end
         fccw_pkg::ST_READ_LO: begin
            state_in = low_cluster ? fccw_pkg::ST_EMIT : fccw_pkg::ST_READ_HI;
         end
         fccw_pkg::ST_READ_HI: begin
            state_in = fccw_pkg::ST_EMIT;
         end
         fccw_pkg::ST_EMIT: begin
            if (out_load) begin
               state_in = res_last ? fccw_pkg::ST_IDLE : fccw_pkg::ST_READ_LO;
            end
         end
         default: state_in = fccw_pkg::ST_IDLE;
      endcase
   end

   // Datapath and output register updates driven by the sequencer.
   always_comb begin
      cur_in         = cur_ff;
      count_in       = count_ff;
      lo_in          = lo_ff;
      lo_oor_in      = lo_oor_ff;
      hi_oor_in      = hi_oor_ff;
      sec_in         = sec_ff;
      out_valid_in   = out_valid_ff && !rsp_tready;
      out_cluster_in = out_cluster_ff;
      out_sector_in  = out_sector_ff;
      out_last_in    = out_last_ff;
      out_err_in     = out_err_ff;
      unique case (state_ff)
         fccw_pkg::ST_IDLE: begin
            if (req_xfer && (req_tuser == fccw_pkg::CMD_WALK)) begin
               cur_in   = req_start;
               count_in = '0;
            end
         end
         fccw_pkg::ST_READ_LO: begin
            lo_oor_in = rd_oor;
         end
         fccw_pkg::ST_READ_HI: begin
            // The low byte arrives now; the sector uses the one multiplier.
            lo_in     = ram_rdata;
            hi_oor_in = rd_oor;
            sec_in    = 20'(dstart_ff) + 20'(cl_off) * 20'(spc_ff);
         end
         fccw_pkg::ST_EMIT: begin
            if (out_load) begin
               out_valid_in   = 1'b1;
               out_cluster_in = cur_ff;
               out_sector_in  = res_sector;
               out_last_in    = res_last;
               out_err_in     = res_err;
               cur_in         = next_cluster;
               count_in       = count_ff + CW'(1);
            end
         end
         default: cur_in = cur_ff;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fccw_pkg::ST_IDLE;
         spc_ff       <= fccw_pkg::SPC_RESET;
         dstart_ff    <= fccw_pkg::DSTART_RESET;
         out_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         spc_ff       <= spc_in;
         dstart_ff    <= dstart_in;
         out_valid_ff <= out_valid_in;
         count_ff     <= count_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      cur_ff         <= cur_in;
      lo_ff          <= lo_in;
      lo_oor_ff      <= lo_oor_in;
      hi_oor_ff      <= hi_oor_in;
      sec_ff         <= sec_in;
      out_cluster_ff <= out_cluster_in;
      out_sector_ff  <= out_sector_in;
      out_last_ff    <= out_last_in;
      out_err_ff     <= out_err_in;
   end

   // Response channel.
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_sector_ff, out_cluster_ff};
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = out_err_ff;

   // Terms observed by the checks below.
   assign chk_err      = rsp_tvalid && (rsp_tuser != fccw_pkg::ERR_NONE);
   assign chk_low      = rsp_tvalid && (rsp_tuser == fccw_pkg::ERR_LOW);
   assign chk_low_ok   = (rsp_tdata[11:0] < fccw_pkg::FIRST_CLUSTER)
                         && (rsp_tdata[31:12] == 20'd0);
   assign chk_busy     = (state_ff != fccw_pkg::ST_IDLE);
   assign chk_count_ok = (count_ff <= CW'(MAX_CHAIN - 1));
   assign chk_more     = out_load && !res_last;
   assign chk_read_lo  = (state_ff == fccw_pkg::ST_READ_LO);

   // Any error ends the walk.
   `FCCW_ASSERT_SAME(a_err_is_last, clock, reset, chk_err, rsp_tlast)
   // A low-cluster result carries a cluster below two and sector zero.
   `FCCW_ASSERT_SAME(a_low_result, clock, reset, chk_low, chk_low_ok)
   // The element count never runs past the chain limit during a walk.
   `FCCW_ASSERT_SAME(a_count_bound, clock, reset, chk_busy, chk_count_ok)
   // A non-final result is followed by the next table read.
   `FCCW_ASSERT_NEXT(a_walk_continues, clock, reset, chk_more, chk_read_lo)

endmodule

// File: tb/tb_fat12_cluster_chain_walk.sv
`timescale 1ns / 100ps

module tb_fat12_cluster_chain_walk;

   localparam int TABLE_SIZE      = 8192;
   localparam int MAX_LINKS       = 64;
   localparam int DIRECTED_ROWS   = 19;
   localparam int PHASE_ITEMS     = 85;
   localparam int SETTLE_CYCLES   = 8;
   localparam int END_CYCLES      = 3 * MAX_LINKS + 16;
   localparam int STALL_CYCLES    = 400;
   localparam int WATCHDOG_LIMIT  = 4000;

   // Codes and markers shared with the block.
   localparam logic        CMD_WRITE     = fccw_pkg::CMD_WRITE;
   localparam logic        CMD_WALK      = fccw_pkg::CMD_WALK;
   localparam logic [1:0]  ERR_NONE      = fccw_pkg::ERR_NONE;
   localparam logic [1:0]  ERR_CHAIN     = fccw_pkg::ERR_CHAIN;
   localparam logic [1:0]  ERR_LOW       = fccw_pkg::ERR_LOW;
   localparam logic        REG_SPC       = fccw_pkg::REG_SPC;
   localparam logic        REG_DSTART    = fccw_pkg::REG_DSTART;
   localparam logic [7:0]  SPC_RESET     = fccw_pkg::SPC_RESET;
   localparam logic [15:0] DSTART_RESET  = fccw_pkg::DSTART_RESET;
   localparam logic [11:0] END_MARK      = fccw_pkg::END_MARK;
   localparam logic [11:0] FIRST_CLUSTER = fccw_pkg::FIRST_CLUSTER;

   // One chain element as it leaves the block.
   typedef struct packed {
      logic [11:0] cluster;
      logic [19:0] first_sector;
      logic        last;
      logic [1:0]  err_code;
   } cluster_result_type;

   // One request transfer, with an optional hand-written expectation.
   typedef struct packed {
      logic               cmd;
      logic [12:0]        addr;
      logic [7:0]         data;
      logic [11:0]        start;
      logic               typed;
      cluster_result_type want;
   } request_type;

   // How the last entry of a generated chain is filled in.
   typedef enum logic [1:0] {
      END_OF_CHAIN,
      TO_LOW_CLUSTER,
      BACK_INTO_CHAIN,
      ANY_VALUE
   } tail_kind_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [39:0] req_tdata;  // table_address[12:0], table_byte[20:13], start_cluster[32:21]
   logic        req_tuser;  // cmd[0]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;  // cluster[11:0], first_sector[31:12]
   logic        rsp_tlast;
   logic [1:0]  rsp_tuser;  // error[1:0]
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // Shadow copy of the allocation table and of the registers.
   bit [7:0]        table_shadow [TABLE_SIZE];
   bit              written_mask [TABLE_SIZE];
   logic [7:0]      spc_shadow    = SPC_RESET;
   logic [15:0]     dstart_shadow = DSTART_RESET;

   cluster_result_type expected_q [$];
   logic [11:0]     known_heads [$];
   int              items_sent     = 0;
   int              mismatch_count = 0;
   bit              pace_requests  = 1'b1;
   bit              pace_responses = 1'b1;
   bit              hold_responses = 1'b0;

   // Directed rows: reset state, extremes, low clusters, self loop, high start.
   request_type directed_rows [DIRECTED_ROWS] = '{
      '{CMD_WALK,  13'd0,    8'h00, 12'd0,    1'b1, '{12'd0,    20'd0,    1'b1, ERR_LOW}},
      '{CMD_WALK,  13'd0,    8'h00, 12'd1,    1'b1, '{12'd1,    20'd0,    1'b1, ERR_LOW}},
      '{CMD_WRITE, 13'd3,    8'hFF, 12'd0,    1'b0, '0},
      '{CMD_WRITE, 13'd4,    8'hFF, 12'd0,    1'b0, '0},
      '{CMD_WRITE, 13'd5,    8'hFF, 12'd0,    1'b0, '0},
      '{CMD_WALK,  13'd0,    8'h00, 12'd2,    1'b1, '{12'd2,    20'd33,   1'b1, ERR_NONE}},
      '{CMD_WALK,  13'd0,    8'h00, 12'd3,    1'b1, '{12'd3,    20'd34,   1'b1, ERR_NONE}},
      '{CMD_WRITE, 13'd6,    8'h04, 12'd0,    1'b0, '0},
      '{CMD_WRITE, 13'd7,    8'h10, 12'd0,    1'b0, '0},
      '{CMD_WRITE, 13'd8,    8'h00, 12'd0,    1'b0, '0},
      '{CMD_WALK,  13'd0,    8'h00, 12'd4,    1'b0, '0},
      '{CMD_WALK,  13'd0,    8'h00, 12'd5,    1'b0, '0},
      '{CMD_WRITE, 13'd6142, 8'hF0, 12'd0,    1'b0, '0},
      '{CMD_WRITE, 13'd6143, 8'hFF, 12'd0,    1'b0, '0},
      '{CMD_WALK,  13'd0,    8'h00, 12'd4095, 1'b1, '{12'd4095, 20'd4126, 1'b1, ERR_NONE}},
      '{CMD_WRITE, 13'd8191, 8'hAA, 12'd0,    1'b0, '0},
      '{CMD_WRITE, 13'd0,    8'h00, 12'd0,    1'b0, '0},
      '{CMD_WALK,  13'd8191, 8'hFF, 12'd2,    1'b1, '{12'd2,    20'd33,   1'b1, ERR_NONE}},
      '{CMD_WRITE, 13'd2,    8'h7F, 12'hFFF,  1'b0, '0}
   };

   fat12_cluster_chain_walk u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Follows a chain through the shadow table. With commit set the elements are queued
   // as expected results; readable tells whether every table byte read was written.
   task automatic follow_chain(input logic [11:0] start, input bit commit,
                               output bit readable);
      logic [11:0]        c;
      logic [11:0]        nxt;
      logic [15:0]        word;
      int                 at;
      int                 k;
      bit                 done;
      cluster_result_type r;
      c        = start;
      readable = 1'b1;
      done     = 1'b0;
      for (k = 0; k < MAX_LINKS && !done; k++) begin
         if (c < FIRST_CLUSTER) begin
            r    = '{c, 20'd0, 1'b1, ERR_LOW};
            done = 1'b1;
         end else begin
            at = int'(c) * 3 / 2;
            if (!written_mask[at] || !written_mask[at + 1]) readable = 1'b0;
            word = {table_shadow[at + 1], table_shadow[at]};
            nxt  = c[0] ? word[15:4] : word[11:0];
            r.cluster      = c;
            r.first_sector = 20'(32'(dstart_shadow) + 32'(c - 12'd2) * 32'(spc_shadow));
            r.last         = (nxt >= END_MARK) || (k + 1 == MAX_LINKS);
            r.err_code     = (nxt >= END_MARK || k + 1 != MAX_LINKS) ? ERR_NONE : ERR_CHAIN;
            done = r.last;
            c    = nxt;
         end
         if (commit) expected_q.push_back(r);
      end
   endtask

   // Offers one request after a random gap and books it once the transfer happens.
   task automatic issue(input request_type item);
      int gap;
      bit readable;
      gap = pace_requests ? $urandom_range(0, 15) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= item.cmd;
      req_tdata  <= {7'd0, item.start, item.data, item.addr};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
      if (item.cmd == CMD_WRITE) begin
         table_shadow[item.addr] = item.data;
         written_mask[item.addr] = 1'b1;
      end else if (item.typed) begin
         expected_q.push_back(item.want);
      end else begin
         follow_chain(item.start, 1'b1, readable);
      end
   endtask

   task automatic send_write(input logic [12:0] addr, input logic [7:0] data);
      request_type item;
      item.cmd   = CMD_WRITE;
      item.addr  = addr;
      item.data  = data;
      item.start = 12'($urandom_range(0, 4095));
      item.typed = 1'b0;
      item.want  = '0;
      issue(item);
   endtask

   // A walk is only sent when every table byte along its path has been written.
   task automatic walk_if_readable(input logic [11:0] start, output bit sent);
      request_type item;
      follow_chain(start, 1'b0, sent);
      if (sent) begin
         item.cmd   = CMD_WALK;
         item.addr  = 13'($urandom_range(0, 8191));
         item.data  = 8'($urandom_range(0, 255));
         item.start = start;
         item.typed = 1'b0;
         item.want  = '0;
         issue(item);
      end
   endtask

   // Rewrites the two bytes that hold one 12-bit entry, keeping the neighbor's nibble.
   task automatic set_entry(input logic [11:0] c, input logic [11:0] v);
      int       at;
      bit [7:0] lo;
      bit [7:0] hi;
      at = int'(c) * 3 / 2;
      lo = table_shadow[at];
      hi = table_shadow[at + 1];
      if (c[0]) begin
         lo = {v[3:0], lo[3:0]};
         hi = v[11:4];
      end else begin
         lo = v[7:0];
         hi = {hi[7:4], v[11:8]};
      end
      send_write(13'(at), lo);
      send_write(13'(at + 1), hi);
   endtask

   // Links distinct random clusters into one chain and returns its head.
   task automatic lay_chain(input int length, input tail_kind_type tail,
                            output logic [11:0] head);
      logic [11:0] links [$];
      bit          used [4096];
      logic [11:0] c;
      logic [11:0] v;
      int          i;
      for (i = 0; i < length; i++) begin
         do c = 12'($urandom_range(2, 4095)); while (used[c]);
         used[c] = 1'b1;
         links.push_back(c);
      end
      for (i = 0; i < length; i++) begin
         if (i + 1 < length) begin
            v = links[i + 1];
         end else begin
            case (tail)
               END_OF_CHAIN:    v = 12'($urandom_range(int'(END_MARK), 4095));
               TO_LOW_CLUSTER:  v = 12'($urandom_range(0, 1));
               BACK_INTO_CHAIN: v = links[$urandom_range(0, length - 1)];
               default:         v = 12'($urandom_range(0, 4095));
            endcase
         end
         set_entry(links[i], v);
      end
      head = links[0];
   endtask

   // One random episode: mostly a fresh chain and its walk, some rewalks, noise and
   // chains broken by a stray write.
   task automatic run_episode();
      int            pick;
      int            r;
      int            n;
      tail_kind_type tail;
      logic [11:0]   head;
      bit            sent;
      pace_requests  = ($urandom_range(0, 3) != 0);
      pace_responses = ($urandom_range(0, 3) != 0);
      pick = $urandom_range(0, 99);
      r    = $urandom_range(0, 9);
      tail = (r < 7) ? END_OF_CHAIN : (r == 7) ? TO_LOW_CLUSTER :
             (r == 8) ? BACK_INTO_CHAIN : ANY_VALUE;
      if (pick < 60) begin
         n = ($urandom_range(0, 29) == 0) ? $urandom_range(60, 66) : $urandom_range(1, 8);
         lay_chain(n, tail, head);
         walk_if_readable(head, sent);
         known_heads.push_back(head);
      end else if (pick < 75) begin
         walk_if_readable(12'($urandom_range(0, 4095)), sent);
         if (!sent && known_heads.size() != 0)
            walk_if_readable(known_heads[$urandom_range(0, known_heads.size() - 1)], sent);
      end else if (pick < 90) begin
         n = $urandom_range(1, 4);
         repeat (n) send_write(13'($urandom_range(0, 8191)), 8'($urandom_range(0, 255)));
      end else begin
         lay_chain($urandom_range(2, 6), END_OF_CHAIN, head);
         send_write(13'(int'(head) * 3 / 2 + $urandom_range(0, 1)),
                    8'($urandom_range(0, 255)));
         walk_if_readable(head, sent);
      end
   endtask

   // Stops offering requests and waits until every expected result has been seen.
   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic index, input logic [31:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (index == REG_SPC) spc_shadow = value[7:0];
      else dstart_shadow = value[15:0];
   endtask

   task automatic report_mismatch(input string what, input cluster_result_type want,
                                  input cluster_result_type got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("[%0t] %s: expected cluster %0d sector %0d last %0b error %0d,",
                  $realtime, what, want.cluster, want.first_sector, want.last,
                  want.err_code,
                  " got cluster %0d sector %0d last %0b error %0d",
                  got.cluster, got.first_sector, got.last, got.err_code);
   endtask

   // Each result transfer is compared with the oldest expectation.
   always @(posedge clock) begin : check_results
      cluster_result_type got;
      cluster_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = '{rsp_tdata[11:0], rsp_tdata[31:12], rsp_tlast, rsp_tuser};
         if (expected_q.size() == 0) begin
            report_mismatch("result with nothing expected", '0, got);
         end else begin
            want = expected_q.pop_front();
            if (got.cluster !== want.cluster || got.first_sector !== want.first_sector ||
                got.last !== want.last || got.err_code !== want.err_code)
               report_mismatch("result mismatch", want, got);
         end
      end
   end

   // Receiver: random ready gaps per result, and one long hold-off on request.
   initial begin : receiver
      int n;
      rsp_tready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_responses) begin
            hold_responses = 1'b0;
            n = STALL_CYCLES;
         end else begin
            n = pace_responses ? $urandom_range(0, 15) : 0;
         end
         if (n > 0) begin
            rsp_tready <= 1'b0;
            repeat (n) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
      end
   end

   // Watchdog: ends the run if no transfer of any kind happens for too long.
   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_psel && csr_penable))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("** fat12_cluster_chain_walk: FAILED **");
      $finish;
   end

   // Stimulus: directed rows, then random phases under several register settings.
   initial begin : stimulus
      int          i;
      int          phase;
      logic [11:0] head;
      bit          sent;
      logic [31:0] spc_value;
      logic [31:0] dstart_value;
      reset       <= 1'b1;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      req_tuser   <= CMD_WRITE;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (i = 0; i < DIRECTED_ROWS; i++) issue(directed_rows[i]);
      wait_for_results();

      for (phase = 0; phase < 6; phase++) begin
         if (phase > 0) begin
            case (phase)
               1: begin spc_value = 32'd128; dstart_value = 32'd65535; end
               2: begin spc_value = 32'd1;   dstart_value = 32'd0;     end
               3: begin spc_value = 32'd0;   dstart_value = 32'd12345; end
               4: begin spc_value = 32'd255; dstart_value = 32'd65535; end
               default: begin spc_value = $urandom(); dstart_value = $urandom(); end
            endcase
            write_register(REG_SPC, spc_value);
            write_register(REG_DSTART, dstart_value);
         end
         // A looping chain while the receiver holds off, so the block backs up.
         if (phase == 1) begin
            hold_responses = 1'b1;
            lay_chain(2, BACK_INTO_CHAIN, head);
            walk_if_readable(head, sent);
         end
         // A chain of exactly the longest length that still ends cleanly.
         if (phase == 2) begin
            lay_chain(MAX_LINKS, END_OF_CHAIN, head);
            walk_if_readable(head, sent);
         end
         while (items_sent < DIRECTED_ROWS + PHASE_ITEMS * (phase + 1)) run_episode();
         wait_for_results();
      end

      repeat (END_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_q.size() == 0)
         $display("** fat12_cluster_chain_walk: PASSED **");
      else
         $display("** fat12_cluster_chain_walk: FAILED **");
      $finish;
   end

endmodule
